[design/lqms_pkg.sv]
// Package with constants shared by the linked queue manager.
`timescale 1ns / 1ps
package lqms_pkg;
  localparam logic [1:0] REQ_MOVE = 2'd0;
  localparam logic [1:0] REQ_SPLICE = 2'd1;
  localparam logic [1:0] REQ_HEAD = 2'd2;
  localparam logic [1:0] REQ_SUCC = 2'd3;
endpackage

[design/linked_queue_move_and_splice.sv]
// Top level: sequencer and pointer memories; a read passes through RD1 and RD2, then offers its answer in OUT.
// One transaction at a time; the next is accepted only once the sequencer is back in IDLE: a move runs
// MV6 and MV1 to MV5, a splice SP5 and SP1 to SP4 (ending after SP2 if the source queue is empty), a
// read RD1, RD2 and OUT (waiting on out_ready); an ignored request ends after MV6 or SP5. The single-port
// read, modify and write of the memories sets these sequences. Reset starts a clearing pass through all
// four memories; no transaction is accepted until it ends. Reset is synchronous and active low.
`timescale 1ns / 1ps
module linked_queue_move_and_splice #(
  parameter int NODE_COUNT = 1023
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_req_type,
  input  logic [9:0] in_first_id,
  input  logic [9:0] in_second_id,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [9:0] out_node_found
);
  localparam int LimInt = (NODE_COUNT < 1023) ? NODE_COUNT : 1023;
  localparam logic [9:0] IdLimit = 10'(LimInt);

  typedef enum logic [15:0] {
    S_INIT = 16'h0001, S_IDLE = 16'h0002, S_RD1 = 16'h0004, S_RD2 = 16'h0008,
    S_MV1 = 16'h0010, S_MV2 = 16'h0020, S_MV3 = 16'h0040, S_MV4 = 16'h0080,
    S_MV5 = 16'h0100, S_MV6 = 16'h0200, S_SP1 = 16'h0400, S_SP2 = 16'h0800,
    S_SP3 = 16'h1000, S_SP4 = 16'h2000, S_OUT = 16'h4000, S_SP5 = 16'h8000
  } state_t;

  logic [9:0]  nxt_mem [2048];
  logic [10:0] prv_mem [1024];
  logic [10:0] tl_mem  [1024];
  logic [9:0]  own_mem [2048];

  state_t state_r;
  logic [9:0] init_r, b_r, c_r, res_r;
  logic init_ph_r;
  logic [1:0] typ_r;
  logic [10:0] ctl_r;
  logic [9:0] first_r;

  // Memory control driven by the sequencer.
  logic [10:0] na, oa;  logic [9:0] pa, ta;
  logic nwe, pwe, twe, owe;
  logic [9:0] nwd, owd; logic [10:0] pwd, twd;
  logic [9:0] nrd, ord; logic [10:0] prd, trd;

  always_ff @(posedge clk) begin
    if (nwe) nxt_mem[na] <= nwd;
    nrd <= nxt_mem[na];
    if (pwe) prv_mem[pa] <= pwd;
    prd <= prv_mem[pa];
    if (twe) tl_mem[ta] <= twd;
    trd <= tl_mem[ta];
    if (owe) own_mem[oa] <= owd;
    ord <= own_mem[oa];
  end

  logic b_ok, c_ok;
  assign b_ok = (b_r != 10'd0) && (b_r <= IdLimit);
  assign c_ok = (c_r != 10'd0) && (c_r <= IdLimit);
  logic iv;
  assign iv = (init_r != 10'd0) && (init_r <= IdLimit);

  always_comb begin
    na = 11'd0; oa = 11'd0; pa = 10'd0; ta = 10'd0;
    nwe = 1'b0; pwe = 1'b0; twe = 1'b0; owe = 1'b0;
    nwd = 10'd0; owd = 10'd0; pwd = 11'd0; twd = 11'd0;
    unique case (state_r)
      S_INIT: begin
        // Clear pass: node entry and head entry of the same index are written in turn as init_ph_r toggles.
        nwe = 1'b1; pwe = 1'b1; twe = 1'b1; owe = 1'b1;
        pa = init_r; ta = init_r;
        pwd = iv ? {1'b1, init_r} : 11'd0;
        twd = iv ? {1'b0, init_r} : 11'd0;
        if (!init_ph_r) begin
          na = {1'b0, init_r}; oa = {1'b0, init_r};
          nwd = 10'd0; owd = iv ? init_r : 10'd0;
        end else begin
          na = {1'b1, init_r}; oa = {1'b1, init_r};
          nwd = iv ? init_r : 10'd0; owd = iv ? init_r : 10'd0;
        end
      end
      S_RD1: na = (typ_r == lqms_pkg::REQ_HEAD) ? {1'b1, b_r} : {1'b0, b_r};
      S_MV1: begin pa = b_r; na = {1'b0, b_r}; oa = {1'b0, b_r}; end
      S_MV2: begin
        // The unlink takes its addresses straight from the data read in MV1.
        nwe = 1'b1; na = prd; nwd = nrd;
        if (nrd != 10'd0) begin pwe = 1'b1; pa = nrd; pwd = prd; end
        else begin
          owe = 1'b1; oa = prd; owd = ord;
          twe = 1'b1; ta = ord; twd = prd;
        end
      end
      S_MV3: begin na = {1'b0, c_r}; oa = {1'b0, c_r}; end
      S_MV4: begin
        nwe = 1'b1; na = {1'b0, b_r}; nwd = nrd;
        if (nrd != 10'd0) begin pwe = 1'b1; pa = nrd; pwd = {1'b0, b_r}; end
        else begin
          twe = 1'b1; ta = ord; twd = {1'b0, b_r};
          owe = 1'b1; oa = {1'b0, b_r}; owd = ord;
        end
      end
      S_MV5: begin
        nwe = 1'b1; na = {1'b0, c_r}; nwd = b_r;
        pwe = 1'b1; pa = b_r; pwd = {1'b0, c_r};
      end
      S_SP1: begin na = {1'b1, b_r}; ta = c_r; end
      S_SP2: ta = b_r;
      S_SP3: begin
        nwe = 1'b1; na = ctl_r; nwd = first_r;
        pwe = 1'b1; pa = first_r; pwd = ctl_r;
        owe = 1'b1; oa = trd; owd = c_r;
        twe = 1'b1; ta = c_r; twd = trd;
      end
      S_SP4: begin
        twe = 1'b1; ta = b_r; twd = {1'b1, b_r};
        nwe = 1'b1; na = {1'b1, b_r}; nwd = 10'd0;
      end
      default: ;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_node_found = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT; init_r <= 10'd0; init_ph_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_INIT: begin
          init_ph_r <= ~init_ph_r;
          if (init_ph_r) begin
            init_r <= init_r + 10'd1;
            if (init_r == 10'd1023) state_r <= S_IDLE;
          end
        end
        S_IDLE: if (in_valid) begin
          typ_r <= in_req_type; b_r <= in_first_id; c_r <= in_second_id;
          unique case (in_req_type)
            lqms_pkg::REQ_HEAD, lqms_pkg::REQ_SUCC: state_r <= S_RD1;
            lqms_pkg::REQ_MOVE: state_r <= S_MV6;
            default: state_r <= S_SP5;
          endcase
        end
        S_MV6: state_r <= (b_r != c_r && b_ok && c_ok) ? S_MV1 : S_IDLE;
        S_SP5: state_r <= (b_r != c_r && b_ok && c_ok) ? S_SP1 : S_IDLE;
        S_RD1: state_r <= S_RD2;
        S_RD2: begin res_r <= b_ok ? nrd : 10'd0; state_r <= S_OUT; end
        S_OUT: if (out_ready) state_r <= S_IDLE;
        S_MV1: state_r <= S_MV2;
        S_MV2: state_r <= S_MV3;
        S_MV3: state_r <= S_MV4;
        S_MV4: state_r <= S_MV5;
        S_MV5: state_r <= S_IDLE;
        S_SP1: state_r <= S_SP2;
        S_SP2: begin
          first_r <= nrd; ctl_r <= trd;
          state_r <= (nrd == 10'd0) ? S_IDLE : S_SP3;
        end
        S_SP3: state_r <= S_SP4;
        S_SP4: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

[verif/linked_queue_move_and_splice_tb.sv]
// Self-checking testbench for the linked queue manager with a queue-state predictor.
`timescale 1ns / 1ps
module linked_queue_move_and_splice_tb;

  localparam int IDLIM = 1023;
  localparam logic [10:0] HEAD_BASE = 11'd1024;
  localparam int STALL_LIMIT = 20000;

  class queue_scoreboard;
    logic [9:0]  nxt [2048];
    logic [10:0] prv [1024];
    logic [10:0] tailq [1024];
    logic [9:0]  owner [2048];
    logic [9:0]  answers [$];
    int errors;
    int reads;

    function void clear_state();
      for (int i = 0; i < 2048; i++) begin
        nxt[i] = '0;
        owner[i] = '0;
      end
      for (int i = 0; i < 1024; i++) begin
        prv[i] = '0;
        tailq[i] = '0;
      end
      for (int i = 1; i <= IDLIM; i++) begin
        nxt[HEAD_BASE + i] = i[9:0];
        prv[i] = HEAD_BASE + i[10:0];
        tailq[i] = i[10:0];
        owner[i] = i[9:0];
        owner[HEAD_BASE + i] = i[9:0];
      end
      errors = 0;
      reads = 0;
    endfunction

    function bit id_ok(logic [9:0] id);
      return id >= 1 && id <= IDLIM;
    endfunction

    function void move_node(logic [9:0] b, logic [9:0] c);
      logic [10:0] bp;
      logic [9:0] bn, cn, q;
      bp = prv[b];
      bn = nxt[b];
      nxt[bp] = bn;
      if (bn != 0) begin
        prv[bn] = bp;
      end else begin
        q = owner[b];
        owner[bp] = q;
        tailq[q] = bp;
      end
      cn = nxt[c];
      nxt[b] = cn;
      if (cn != 0) begin
        prv[cn] = {1'b0, b};
      end else begin
        q = owner[c];
        tailq[q] = {1'b0, b};
        owner[b] = q;
      end
      nxt[c] = b;
      prv[b] = {1'b0, c};
    endfunction

    function void splice_queue(logic [9:0] b, logic [9:0] c);
      logic [10:0] hb, ct, bt;
      logic [9:0] first;
      hb = HEAD_BASE + b;
      first = nxt[hb];
      if (first == 0) return;
      ct = tailq[c];
      bt = tailq[b];
      nxt[ct] = first;
      prv[first] = ct;
      owner[bt] = c;
      tailq[c] = bt;
      tailq[b] = hb;
      nxt[hb] = '0;
    endfunction

    function void note_request(logic [1:0] t, logic [9:0] b, logic [9:0] c);
      case (t)
        lqms_pkg::REQ_HEAD: answers.push_back(id_ok(b) ? nxt[HEAD_BASE + b] : 10'd0);
        lqms_pkg::REQ_SUCC: answers.push_back(id_ok(b) ? nxt[b] : 10'd0);
        default: begin
          if (b != c && id_ok(b) && id_ok(c)) begin
            if (t == lqms_pkg::REQ_MOVE) move_node(b, c);
            else splice_queue(b, c);
          end
        end
      endcase
    endfunction

    function void check_answer(logic [9:0] got);
      logic [9:0] exp_node;
      reads++;
      if (answers.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d", $realtime, got);
        errors++;
        return;
      end
      exp_node = answers.pop_front();
      if (got !== exp_node) begin
        $display("%0t: node_found mismatch, expected %0d, actual %0d",
                 $realtime, exp_node, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_req_type = '0;
  logic [9:0] in_first_id = '0;
  logic [9:0] in_second_id = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [9:0] out_node_found;

  queue_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int stall_count;
  int accepted;

  always #6 clk = ~clk;

  linked_queue_move_and_splice i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_req_type(in_req_type), .in_first_id(in_first_id), .in_second_id(in_second_id),
    .out_valid(out_valid), .out_ready(out_ready), .out_node_found(out_node_found)
  );

  // Results are checked at the rising edge where the transaction completes.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_answer(out_node_found);
    if (rst_n && in_valid && in_ready) begin
      sb.note_request(in_req_type, in_first_id, in_second_id);
      accepted++;
    end
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) stall_count = 0;
    else stall_count++;
    if (stall_count >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Valid stays high on return, so the next request can follow without a gap.
  task automatic send_request(logic [1:0] t, logic [9:0] b, logic [9:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= t;
    in_first_id <= b;
    in_second_id <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.answers.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  function automatic logic [9:0] pick_id();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 10'($urandom_range(12, 1));
    if (r < 53) return 10'd0;
    if (r < 56) return 10'd1023;
    return 10'($urandom_range(1023, 1));
  endfunction

  task automatic random_phase(int count);
    logic [1:0] t;
    logic [9:0] b;
    for (int n = 0; n < count; n++) begin
      t = 2'($urandom_range(3));
      b = pick_id();
      send_request(t, b, ($urandom_range(19) == 0) ? b : pick_id());
    end
  endtask

  initial begin
    sb = new();
    sb.clear_state();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    accepted = 0;
    stall_count = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reads at reset, same ids, empty source, bad ids, extremes.
    send_request(lqms_pkg::REQ_HEAD, 10'd1, 10'd0);
    send_request(lqms_pkg::REQ_SUCC, 10'd1023, 10'd0);
    send_request(lqms_pkg::REQ_HEAD, 10'd0, 10'd5);
    send_request(lqms_pkg::REQ_SUCC, 10'd0, 10'd5);
    send_request(lqms_pkg::REQ_MOVE, 10'd3, 10'd3);
    send_request(lqms_pkg::REQ_SPLICE, 10'd4, 10'd4);
    send_request(lqms_pkg::REQ_MOVE, 10'd0, 10'd7);
    send_request(lqms_pkg::REQ_SPLICE, 10'd7, 10'd0);
    send_request(lqms_pkg::REQ_MOVE, 10'd2, 10'd1);
    send_request(lqms_pkg::REQ_SUCC, 10'd1, 10'd0);
    send_request(lqms_pkg::REQ_HEAD, 10'd2, 10'd0);
    send_request(lqms_pkg::REQ_SPLICE, 10'd2, 10'd5);
    send_request(lqms_pkg::REQ_SPLICE, 10'd1, 10'd1023);
    send_request(lqms_pkg::REQ_HEAD, 10'd1023, 10'd0);
    send_request(lqms_pkg::REQ_SUCC, 10'd1023, 10'd0);
    send_request(lqms_pkg::REQ_SUCC, 10'd1, 10'd0);
    send_request(lqms_pkg::REQ_MOVE, 10'd1023, 10'd682);
    send_request(lqms_pkg::REQ_SUCC, 10'd682, 10'd341);
    send_request(lqms_pkg::REQ_HEAD, 10'd341, 10'd682);
    drain_results();

    send_idle_pct = 13;
    recv_idle_pct = 48;
    random_phase(410);
    drain_results();
    send_idle_pct = 48;
    recv_idle_pct = 13;
    random_phase(410);
    drain_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(410);
    drain_results();

    $display("Covered %0d requests, %0d read answers, moves, splices and invalid ids.",
             accepted, sb.reads);
    if (sb.errors == 0 && sb.answers.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
